>>> rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the max-heap priority queue: action and status
// codes, controller states, datapath commands and datapath status flags.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   // Action codes carried on the request channel.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // Status codes returned with every result item.
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_FULL_DROP  = 2'd1;
   localparam logic [1:0] STAT_EMPTY_REMV = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHECK,
      ST_UP_COMPARE,
      ST_DOWN_LAST,
      ST_DOWN_CHECK,
      ST_DOWN_RIGHT,
      ST_DOWN_COMPARE,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_QUERY,
      CMD_REJECT_FULL,
      CMD_REJECT_EMPTY,
      CMD_INS_START,
      CMD_DEL_START,
      CMD_UP_READ,
      CMD_UP_MOVE,
      CMD_WRITE_ENTRY,
      CMD_LOAD_LAST,
      CMD_READ_LEFT,
      CMD_READ_RIGHT,
      CMD_DOWN_MOVE,
      CMD_PUBLISH
   } cmd_type;

   typedef struct packed {
      logic full;       // heap holds HEAP_DEPTH entries
      logic empty;      // heap holds no entry
      logic pos_zero;   // sift position is the root
      logic up_move;    // parent has strictly lower priority than the entry
      logic left_in;    // left child of the sift position exists
      logic down_move;  // chosen child has strictly higher priority
   } dp_status_type;

endpackage

>>> rtl/core/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Controller state machine: accepts request items, steps the datapath
// through sift-up and sift-down, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::cmd_type      dp_cmd
);

   mhpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_take;
   logic                out_free;

   assign req_stall = (state_ff != mhpq_pkg::ST_IDLE);
   assign req_take  = req_valid && (state_ff == mhpq_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dp_cmd       = mhpq_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_action)
                  mhpq_pkg::ACT_INSERT: begin
                     if (dp_status.full) begin
                        dp_cmd   = mhpq_pkg::CMD_REJECT_FULL;
                        state_in = mhpq_pkg::ST_FINISH;
                     end else begin
                        dp_cmd   = mhpq_pkg::CMD_INS_START;
                        state_in = mhpq_pkg::ST_UP_CHECK;
                     end
                  end
                  mhpq_pkg::ACT_REMOVE: begin
                     if (dp_status.empty) begin
                        dp_cmd   = mhpq_pkg::CMD_REJECT_EMPTY;
                        state_in = mhpq_pkg::ST_FINISH;
                     end else begin
                        dp_cmd   = mhpq_pkg::CMD_DEL_START;
                        state_in = mhpq_pkg::ST_DOWN_LAST;
                     end
                  end
                  default: begin
                     dp_cmd   = mhpq_pkg::CMD_QUERY;
                     state_in = mhpq_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         mhpq_pkg::ST_UP_CHECK: begin
            if (dp_status.pos_zero) begin
               dp_cmd   = mhpq_pkg::CMD_WRITE_ENTRY;
               state_in = mhpq_pkg::ST_FINISH;
            end else begin
               dp_cmd   = mhpq_pkg::CMD_UP_READ;
               state_in = mhpq_pkg::ST_UP_COMPARE;
            end
         end
         mhpq_pkg::ST_UP_COMPARE: begin
            if (dp_status.up_move) begin
               dp_cmd   = mhpq_pkg::CMD_UP_MOVE;
               state_in = mhpq_pkg::ST_UP_CHECK;
            end else begin
               dp_cmd   = mhpq_pkg::CMD_WRITE_ENTRY;
               state_in = mhpq_pkg::ST_FINISH;
            end
         end
         mhpq_pkg::ST_DOWN_LAST: begin
            dp_cmd = mhpq_pkg::CMD_LOAD_LAST;
            if (dp_status.empty) begin
               state_in = mhpq_pkg::ST_FINISH;
            end else begin
               state_in = mhpq_pkg::ST_DOWN_CHECK;
            end
         end
         mhpq_pkg::ST_DOWN_CHECK: begin
            if (dp_status.left_in) begin
               dp_cmd   = mhpq_pkg::CMD_READ_LEFT;
               state_in = mhpq_pkg::ST_DOWN_RIGHT;
            end else begin
               dp_cmd   = mhpq_pkg::CMD_WRITE_ENTRY;
               state_in = mhpq_pkg::ST_FINISH;
            end
         end
         mhpq_pkg::ST_DOWN_RIGHT: begin
            dp_cmd   = mhpq_pkg::CMD_READ_RIGHT;
            state_in = mhpq_pkg::ST_DOWN_COMPARE;
         end
         mhpq_pkg::ST_DOWN_COMPARE: begin
            if (dp_status.down_move) begin
               dp_cmd   = mhpq_pkg::CMD_DOWN_MOVE;
               state_in = mhpq_pkg::ST_DOWN_CHECK;
            end else begin
               dp_cmd   = mhpq_pkg::CMD_WRITE_ENTRY;
               state_in = mhpq_pkg::ST_FINISH;
            end
         end
         mhpq_pkg::ST_FINISH: begin
            if (out_free) begin
               dp_cmd       = mhpq_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = mhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // An accepted item always starts work in the next cycle.
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != mhpq_pkg::ST_IDLE))
      else $error("controller stayed idle after taking an item");

   // A result is only published while the output register can take it.
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == mhpq_pkg::CMD_PUBLISH) |-> out_free)
      else $error("result published over a pending result");
`endif

endmodule

>>> rtl/core/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp
// Datapath: heap memory with one write and one registered read port, the
// entry being sifted, the sift position, the fill count, a copy of the root
// entry and the result register.
// ----------------------------------------------------------------------------
module mhpq_dp #(
   parameter int HEAP_DEPTH    = 64,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mhpq_pkg::cmd_type       dp_cmd,
   output mhpq_pkg::dp_status_type dp_status,
   input  logic [7:0]              req_job_priority,
   input  logic [15:0]             req_job_id,
   input  logic [15:0]             req_page_count,
   output logic [7:0]              rsp_top_priority,
   output logic [15:0]             rsp_top_job_id,
   output logic [15:0]             rsp_top_pages,
   output logic                    rsp_is_empty,
   output logic [6:0]              rsp_entry_count,
   output logic [1:0]              rsp_status
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int FW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;
   localparam logic [FW-1:0] DEPTH_C = FW'(HEAP_DEPTH);

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [15:0]              id;
      logic [15:0]              pages;
   } entry_type;

   entry_type heap_mem [HEAP_DEPTH];

   entry_type       rdata_ff;
   entry_type       ent_ff, ent_in;
   entry_type       left_ff, left_in;
   entry_type       top_ff, top_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [1:0]      stat_ff, stat_in;

   logic [7:0]      rsp_prio_ff;
   logic [15:0]     rsp_id_ff;
   logic [15:0]     rsp_pages_ff;
   logic            rsp_empty_ff;
   logic [6:0]      rsp_count_ff;
   logic [1:0]      rsp_stat_ff;
   logic            publish;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   logic [AW-1:0]   parent_addr;
   logic [IW-1:0]   left_idx;
   logic [IW-1:0]   right_idx;
   logic [IW-1:0]   fill_ext;
   logic            right_in;
   entry_type       pick;
   logic [AW-1:0]   pick_addr;
   entry_type       req_entry;

   assign parent_addr = (pos_ff - AW'(1)) >> 1;
   assign left_idx    = {1'b0, pos_ff, 1'b1};
   assign right_idx   = left_idx + IW'(1);
   assign fill_ext    = IW'(fill_ff);
   assign right_in    = right_idx < fill_ext;

   // Larger child wins; the right child wins a tie.
   always_comb begin
      if (right_in && (rdata_ff.prio >= left_ff.prio)) begin
         pick      = rdata_ff;
         pick_addr = AW'(right_idx);
      end else begin
         pick      = left_ff;
         pick_addr = AW'(left_idx);
      end
   end

   assign req_entry.prio  = PRIORITY_BITS'(req_job_priority);
   assign req_entry.id    = req_job_id;
   assign req_entry.pages = req_page_count;

   assign dp_status.full      = (fill_ff == DEPTH_C);
   assign dp_status.empty     = (fill_ff == '0);
   assign dp_status.pos_zero  = (pos_ff == '0);
   assign dp_status.up_move   = (rdata_ff.prio < ent_ff.prio);
   assign dp_status.left_in   = (left_idx < fill_ext);
   assign dp_status.down_move = (pick.prio > ent_ff.prio);

   always_comb begin
      ent_in  = ent_ff;
      left_in = left_ff;
      pos_in  = pos_ff;
      fill_in = fill_ff;
      stat_in = stat_ff;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = ent_ff;
      rd_en   = 1'b0;
      rd_addr = pos_ff;
      publish = 1'b0;
      case (dp_cmd)
         mhpq_pkg::CMD_QUERY:        stat_in = mhpq_pkg::STAT_OK;
         mhpq_pkg::CMD_REJECT_FULL:  stat_in = mhpq_pkg::STAT_FULL_DROP;
         mhpq_pkg::CMD_REJECT_EMPTY: stat_in = mhpq_pkg::STAT_EMPTY_REMV;
         mhpq_pkg::CMD_INS_START: begin
            stat_in = mhpq_pkg::STAT_OK;
            ent_in  = req_entry;
            pos_in  = AW'(fill_ff);
            fill_in = fill_ff + FW'(1);
         end
         mhpq_pkg::CMD_DEL_START: begin
            stat_in = mhpq_pkg::STAT_OK;
            rd_en   = 1'b1;
            rd_addr = AW'(fill_ff - FW'(1));
            fill_in = fill_ff - FW'(1);
            pos_in  = '0;
         end
         mhpq_pkg::CMD_UP_READ: begin
            rd_en   = 1'b1;
            rd_addr = parent_addr;
         end
         mhpq_pkg::CMD_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rdata_ff;
            pos_in  = parent_addr;
         end
         mhpq_pkg::CMD_WRITE_ENTRY: begin
            wr_en = 1'b1;
         end
         mhpq_pkg::CMD_LOAD_LAST: begin
            ent_in = rdata_ff;
         end
         mhpq_pkg::CMD_READ_LEFT: begin
            rd_en   = 1'b1;
            rd_addr = AW'(left_idx);
         end
         mhpq_pkg::CMD_READ_RIGHT: begin
            left_in = rdata_ff;
            rd_en   = 1'b1;
            rd_addr = AW'(right_idx);
         end
         mhpq_pkg::CMD_DOWN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = pick;
            pos_in  = pick_addr;
         end
         mhpq_pkg::CMD_PUBLISH: begin
            publish = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The root copy follows every write to the first slot.
   assign top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= heap_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      left_ff <= left_in;
      top_ff  <= top_in;
      pos_ff  <= pos_in;
      stat_ff <= stat_in;
      if (publish) begin
         rsp_empty_ff <= (fill_ff == '0);
         rsp_count_ff <= 7'(fill_ff);
         rsp_stat_ff  <= stat_ff;
         if (fill_ff == '0) begin
            rsp_prio_ff  <= '0;
            rsp_id_ff    <= '0;
            rsp_pages_ff <= '0;
         end else begin
            rsp_prio_ff  <= 8'(top_ff.prio);
            rsp_id_ff    <= top_ff.id;
            rsp_pages_ff <= top_ff.pages;
         end
      end
   end

   assign rsp_top_priority = rsp_prio_ff;
   assign rsp_top_job_id   = rsp_id_ff;
   assign rsp_top_pages    = rsp_pages_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_status       = rsp_stat_ff;

`ifndef SYNTHESIS
   // The fill count never passes the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill count above heap depth");

   // Every heap write lands inside the occupied part of the heap.
   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (FW'(wr_addr) < fill_ff))
      else $error("heap write beyond the fill count");
`endif

endmodule

>>> rtl/core/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of print jobs: insert, extract-max and query, with the top
// entry, empty flag, entry count and a status reported for every item.
// ----------------------------------------------------------------------------
// Usage:
//   Request items arrive on req_* and are taken at a clock edge where
//   req_valid is high and req_stall is low. Each item gives exactly one
//   result item on rsp_*, taken where rsp_valid is high and rsp_stall low.
//   An insert sifts up one level at a time, each level through ST_UP_CHECK
//   and ST_UP_COMPARE; a remove loads the last entry and sifts it down from
//   the root, each level through ST_DOWN_CHECK, ST_DOWN_RIGHT and
//   ST_DOWN_COMPARE, on a heap memory with one write and one read port. One
//   item is in work at a time; the next can be taken in the cycle after
//   publishing, since req_stall is high until the result moves into the
//   output register, which may still hold an earlier result waiting on
//   rsp_stall. A stalled result holds steady. Reset empties the heap at once
//   and drops any pending result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
   parameter int HEAP_DEPTH    = 64,
   parameter int PRIORITY_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_job_priority,
   input  logic [15:0] req_job_id,
   input  logic [15:0] req_page_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_top_priority,
   output logic [15:0] rsp_top_job_id,
   output logic [15:0] rsp_top_pages,
   output logic        rsp_is_empty,
   output logic [6:0]  rsp_entry_count,
   output logic [1:0]  rsp_status
);

   // Command and status between the sequencer and the heap datapath.
   mhpq_pkg::cmd_type       dp_cmd;
   mhpq_pkg::dp_status_type dp_status;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   mhpq_dp #(
      .HEAP_DEPTH    (HEAP_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_job_priority (req_job_priority),
      .req_job_id       (req_job_id),
      .req_page_count   (req_page_count),
      .rsp_top_priority (rsp_top_priority),
      .rsp_top_job_id   (rsp_top_job_id),
      .rsp_top_pages    (rsp_top_pages),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

endmodule

>>> sim/max_heap_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking bench for the print-job max-heap. A shadow heap in the bench
// predicts the top entry, empty flag, entry count and status for every item.
// Directed tests cover empty and full heaps and the tie rules. A long output
// hold fills the block, and a randomized mix with random idling on both
// channels covers the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

   localparam int HEAP_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_PAUSE = 30;

   // The block treats the unused fourth action code as a query.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   // One job as the shadow heap stores it.
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] id;
      logic [15:0] pages;
   } job_entry_type;

   // One predicted result item.
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] id;
      logic [15:0] pages;
      logic        empty;
      logic [6:0]  count;
      logic [1:0]  status;
   } heap_result_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action       = mhpq_pkg::ACT_QUERY;
   logic [7:0]  req_job_priority = '0;
   logic [15:0] req_job_id       = '0;
   logic [15:0] req_page_count   = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_top_priority;
   logic [15:0] rsp_top_job_id;
   logic [15:0] rsp_top_pages;
   logic        rsp_is_empty;
   logic [6:0]  rsp_entry_count;
   logic [1:0]  rsp_status;

   max_heap_priority_queue #(
      .HEAP_DEPTH    (HEAP_DEPTH),
      .PRIORITY_BITS (8)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_job_priority (req_job_priority),
      .req_job_id       (req_job_id),
      .req_page_count   (req_page_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_top_priority (rsp_top_priority),
      .rsp_top_job_id   (rsp_top_job_id),
      .rsp_top_pages    (rsp_top_pages),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

   // Shadow copy of the heap and the results still owed by the block.
   job_entry_type   shadow_heap [HEAP_DEPTH];
   int              shadow_fill = 0;
   heap_result_type expected_tops [$];

   // Idle percentages for each side; the test tasks change them per phase.
   int sender_idle_pct   = 30;
   int receiver_idle_pct = 30;

   // A nonzero value asks the receiver process for a long hold whose length it sets.
   int hold_request = 0;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int n_inserts = 0, n_drops = 0, n_removes = 0, n_empty_removes = 0, n_queries = 0;
   int peak_fill = 0;
   int n_holds   = 0;

   // 8 ns clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_tops.size());
         $display("max_heap_priority_queue_tb: done, errors");
         $finish;
      end
   end

   // Length of the next idle run: usually none, mostly short, sometimes long.
   function automatic int pick_run(input int pct);
      if ($urandom_range(99, 0) < pct) begin
         if ($urandom_range(9, 0) == 0)
            return $urandom_range(50, 15);
         return $urandom_range(3, 1);
      end
      return 0;
   endfunction

   // Applies one item to the shadow heap and returns the result the block must give.
   // Inserts sift up past parents of strictly lower priority. Removes move the
   // last entry to the root and sift it down toward the larger child, taking the
   // right child on a tie, and only while that child is strictly higher.
   function automatic heap_result_type apply_job(input logic [1:0] act,
                                                 input logic [7:0] prio,
                                                 input logic [15:0] id,
                                                 input logic [15:0] pages);
      heap_result_type res;
      job_entry_type   ent;
      int              pos;
      int              parent;
      int              left;
      int              pick;
      res = '0;
      res.status = mhpq_pkg::STAT_OK;
      if (act == mhpq_pkg::ACT_INSERT) begin
         if (shadow_fill >= HEAP_DEPTH) begin
            res.status = mhpq_pkg::STAT_FULL_DROP;
         end else begin
            ent = '{prio: prio, id: id, pages: pages};
            pos = shadow_fill;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_heap[parent].prio < ent.prio) begin
                  shadow_heap[pos] = shadow_heap[parent];
                  pos = parent;
               end else begin
                  break;
               end
            end
            shadow_heap[pos] = ent;
            shadow_fill++;
         end
      end else if (act == mhpq_pkg::ACT_REMOVE) begin
         if (shadow_fill == 0) begin
            res.status = mhpq_pkg::STAT_EMPTY_REMV;
         end else begin
            ent = shadow_heap[shadow_fill - 1];
            shadow_fill--;
            if (shadow_fill > 0) begin
               pos = 0;
               forever begin
                  left = 2 * pos + 1;
                  if (left >= shadow_fill)
                     break;
                  pick = left;
                  if (left + 1 < shadow_fill &&
                      shadow_heap[left + 1].prio >= shadow_heap[left].prio)
                     pick = left + 1;
                  if (shadow_heap[pick].prio > ent.prio) begin
                     shadow_heap[pos] = shadow_heap[pick];
                     pos = pick;
                  end else begin
                     break;
                  end
               end
               shadow_heap[pos] = ent;
            end
         end
      end
      // Queries and the spare code leave the heap as it is.
      if (shadow_fill == 0) begin
         res.empty = 1'b1;
      end else begin
         res.prio  = shadow_heap[0].prio;
         res.id    = shadow_heap[0].id;
         res.pages = shadow_heap[0].pages;
      end
      res.count = shadow_fill[6:0];
      return res;
   endfunction

   // Offers one item after a random idle run and waits until the block takes it.
   // Valid stays high when the next item follows without a gap, so it is never
   // lowered and raised in the same step. The prediction is made at the edge
   // where the item is accepted.
   task automatic send_item(input logic [1:0] act, input logic [7:0] prio,
                            input logic [15:0] id, input logic [15:0] pages);
      int              gap;
      heap_result_type res;
      gap = pick_run(sender_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_job_priority <= prio;
      req_job_id       <= id;
      req_page_count   <= pages;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      res = apply_job(act, prio, id, pages);
      expected_tops.push_back(res);
      case (act)
         mhpq_pkg::ACT_INSERT: begin
            n_inserts++;
            if (res.status == mhpq_pkg::STAT_FULL_DROP)
               n_drops++;
         end
         mhpq_pkg::ACT_REMOVE: begin
            n_removes++;
            if (res.status == mhpq_pkg::STAT_EMPTY_REMV)
               n_empty_removes++;
         end
         default: n_queries++;
      endcase
      if (shadow_fill > peak_fill)
         peak_fill = shadow_fill;
   endtask

   // Random job fields; on removes and queries these are noise the block must ignore.
   task automatic send_random(input logic [1:0] act);
      send_item(act, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Drops valid and waits until every owed result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tops.size() != 0)
         @(posedge clock);
   endtask

   // Receiver side: random stall runs, or a long hold when a test asks for one.
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (hold_request > 0) begin
         rsp_stall    <= 1'b1;
         stall_left   = hold_request - 1;
         hold_request = 0;
         n_holds++;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(99, 0) < receiver_idle_pct) begin
         rsp_stall  <= 1'b1;
         stall_left = pick_run(100) - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = $urandom_range(4, 0);
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Every result taken by the receiver is compared with the oldest prediction.
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tops.size() == 0) begin
            $display("%0t: result with no item outstanding (top 0x%0h, count %0d)",
                     $time, rsp_top_priority, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = expected_tops.pop_front();
            check_field("top_priority", 16'(want.prio), 16'(rsp_top_priority));
            check_field("top_job_id", want.id, rsp_top_job_id);
            check_field("top_pages", want.pages, rsp_top_pages);
            check_field("is_empty", 16'(want.empty), 16'(rsp_is_empty));
            check_field("entry_count", 16'(want.count), 16'(rsp_entry_count));
            check_field("status", 16'(want.status), 16'(rsp_status));
            results_checked++;
         end
      end
   end

   // Queries, removes and the spare code on an empty heap, with noisy job fields.
   task automatic test_empty_heap();
      send_item(mhpq_pkg::ACT_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(mhpq_pkg::ACT_REMOVE, 8'hA5, 16'h5A5A, 16'hC3C3);
      send_item(ACT_SPARE, 8'h00, 16'h0000, 16'h0000);
      send_item(mhpq_pkg::ACT_REMOVE, 8'h00, 16'h0000, 16'h0000);
   endtask

   // Extreme field values, equal priorities on the way up, and the right-child
   // choice when both children tie on the way down.
   task automatic test_heap_order();
      send_item(mhpq_pkg::ACT_INSERT, 8'h00, 16'h0000, 16'h0000);
      send_item(mhpq_pkg::ACT_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
      // Same priority as the root: the newcomer must not overtake it.
      send_item(mhpq_pkg::ACT_INSERT, 8'hFF, 16'h1234, 16'h4321);
      send_item(mhpq_pkg::ACT_QUERY, 8'h55, 16'hAAAA, 16'h5555);
      send_item(mhpq_pkg::ACT_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(mhpq_pkg::ACT_REMOVE, 8'h00, 16'h0000, 16'h0000);
      send_item(mhpq_pkg::ACT_REMOVE, 8'h00, 16'h0000, 16'h0000);
      send_item(ACT_SPARE, 8'h77, 16'h7777, 16'h7777);
      // Root 10 with two children of priority 7, then a small leaf. The first
      // remove must lift the right child, the second the left one.
      send_item(mhpq_pkg::ACT_INSERT, 8'd10, 16'h0A00, 16'd1);
      send_item(mhpq_pkg::ACT_INSERT, 8'd7, 16'h0701, 16'd2);
      send_item(mhpq_pkg::ACT_INSERT, 8'd7, 16'h0702, 16'd3);
      send_item(mhpq_pkg::ACT_INSERT, 8'd3, 16'h0300, 16'd4);
      send_item(mhpq_pkg::ACT_REMOVE, 8'd0, 16'h0, 16'h0);
      send_item(mhpq_pkg::ACT_REMOVE, 8'd0, 16'h0, 16'h0);
      send_item(mhpq_pkg::ACT_REMOVE, 8'd0, 16'h0, 16'h0);
      send_item(mhpq_pkg::ACT_REMOVE, 8'd0, 16'h0, 16'h0);
      send_item(mhpq_pkg::ACT_QUERY, 8'd0, 16'h0, 16'h0);
   endtask

   // Fills the heap to its depth, inserts into the full heap, then empties it.
   task automatic test_full_heap();
      repeat (HEAP_DEPTH)
         send_random(mhpq_pkg::ACT_INSERT);
      send_item(mhpq_pkg::ACT_INSERT, 8'hFF, 16'hBEEF, 16'hFFFF);
      send_random(mhpq_pkg::ACT_INSERT);
      send_random(mhpq_pkg::ACT_REMOVE);
      send_random(mhpq_pkg::ACT_INSERT);
      send_random(mhpq_pkg::ACT_INSERT);
      repeat (HEAP_DEPTH + 1)
         send_random(mhpq_pkg::ACT_REMOVE);
      send_random(mhpq_pkg::ACT_QUERY);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // items back to back, so the output register and the item in work both fill
   // and the block has to stall its input.
   task automatic test_output_hold();
      sender_idle_pct = 0;
      hold_request    = 300;
      repeat (16)
         send_random($urandom_range(1, 0) ? mhpq_pkg::ACT_INSERT : mhpq_pkg::ACT_REMOVE);
      wait_drained();
      sender_idle_pct = 30;
   endtask

   // Randomized traffic in phases. Each phase leans toward inserts, removes or
   // neither, draws priorities from a narrow range (many ties), from the
   // extremes or from the full range, and picks its own idling on both sides,
   // one kind of phase having none at all.
   task automatic test_random_traffic(input int n_items);
      int          sent;
      int          phase;
      int          ins_pct;
      int          prio_mode;
      int          roll;
      logic [1:0]  act;
      logic [7:0]  prio;
      sent  = 0;
      phase = 0;
      while (sent < n_items) begin
         case ($urandom_range(2, 0))
            0:       ins_pct = 80;
            1:       ins_pct = 25;
            default: ins_pct = 50;
         endcase
         prio_mode = $urandom_range(2, 0);
         case (phase % 4)
            0: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
            1: begin
               sender_idle_pct   = 60;
               receiver_idle_pct = 10;
            end
            2: begin
               sender_idle_pct   = 10;
               receiver_idle_pct = 60;
            end
            default: begin
               sender_idle_pct   = 30;
               receiver_idle_pct = 30;
            end
         endcase
         repeat (100) begin
            roll = $urandom_range(99, 0);
            if (roll < ins_pct)
               act = mhpq_pkg::ACT_INSERT;
            else if (roll < 92)
               act = mhpq_pkg::ACT_REMOVE;
            else if (roll < 97)
               act = mhpq_pkg::ACT_QUERY;
            else
               act = ACT_SPARE;
            case (prio_mode)
               0:       prio = 8'($urandom_range(3, 0));
               1:       prio = $urandom_range(1, 0) ? 8'($urandom_range(255, 252))
                                                    : 8'($urandom_range(3, 0));
               default: prio = 8'($urandom);
            endcase
            send_item(act, prio, 16'($urandom), 16'($urandom));
            sent++;
         end
         // Now and then the sender waits for every result before going on.
         if (phase % 3 == 2)
            wait_drained();
         phase++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_heap();
      test_heap_order();
      test_full_heap();
      wait_drained();
      test_output_hold();
      test_random_traffic(1000);

      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      $display("Checked %0d results: %0d inserts (%0d dropped when full), %0d removes",
               results_checked, n_inserts, n_drops, n_removes);
      $display("(%0d on an empty heap), %0d queries, peak fill %0d, %0d long output holds.",
               n_empty_removes, n_queries, peak_fill, n_holds);
      if (mismatch_count == 0 && expected_tops.size() == 0) begin
         $display("max_heap_priority_queue_tb: done, clean");
      end else begin
         $display("max_heap_priority_queue_tb: done, errors");
      end
      $finish;
   end

endmodule
